/* rtl/sorted_priority_queue_macros.svh */
// Assertion helpers for the sorted priority queue.
// Each macro expects clk and arst_n in scope.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Check a property at every rising edge outside reset.
`define SPQ_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("sorted_priority_queue: assertion failed");

// Check that a condition in one cycle implies a result in the next.
`define SPQ_ASSERT_NEXT(label, cond, result) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (result)) \
		else $error("sorted_priority_queue: next-cycle assertion failed");

`endif

/* rtl/spq_pkg.sv */
package spq_pkg;

	localparam int DEPTH     = 16;
	localparam int PRIO_BITS = 8;
	localparam int VALUE_W   = 32;
	localparam int PRIO_W    = 8;
	localparam int COUNT_W   = 5;
	localparam int CNT_W     = $clog2(DEPTH + 1);

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [PRIO_BITS-1:0]      prio;
	} entry_t;

	// Broadcast to every cell in the chain.
	typedef struct packed {
		logic   enq;
		logic   deq;
		entry_t ent;
	} cell_ctrl_t;

	typedef struct packed {
		status_t                   status;
		logic                      out_valid;
		logic signed [VALUE_W-1:0] out_value;
		logic [PRIO_W-1:0]         out_prio;
		logic [COUNT_W-1:0]        count;
	} result_t;

	// Keep the low PRIO_BITS of a port priority.
	function automatic logic [PRIO_BITS-1:0] prio_to_store(input logic [PRIO_W-1:0] p);
		logic [PRIO_BITS+PRIO_W-1:0] w;
		w = {{PRIO_BITS{1'b0}}, p};
		return w[PRIO_BITS-1:0];
	endfunction

	// Widen or cut a stored priority to the port width.
	function automatic logic [PRIO_W-1:0] prio_to_port(input logic [PRIO_BITS-1:0] p);
		logic [PRIO_BITS+PRIO_W-1:0] w;
		w = {{PRIO_W{1'b0}}, p};
		return w[PRIO_W-1:0];
	endfunction

	// Report the fill level in the count field width.
	function automatic logic [COUNT_W-1:0] fill_to_count(input logic [CNT_W-1:0] f);
		logic [CNT_W+COUNT_W-1:0] w;
		w = {{COUNT_W{1'b0}}, f};
		return w[COUNT_W-1:0];
	endfunction

endpackage

/* rtl/spq_cell.sv */
module spq_cell import spq_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       occ,
	input  entry_t     left_ent,
	input  logic       left_gt,
	input  entry_t     right_ent,
	output entry_t     ent,
	output logic       gt
);

	entry_t ent_q;
	entry_t ent_d;

	// Flag an occupied slot that must move behind the new word.
	assign gt  = occ && (ent_q.prio > ctrl.ent.prio);
	assign ent = ent_q;

	// Pick shift-in from left, new word, shift-in from right, or hold.
	always_comb begin
		ent_d = ent_q;
		if (ctrl.enq) begin
			if (left_gt) begin
				ent_d = left_ent;
			end else if (gt || !occ) begin
				ent_d = ctrl.ent;
			end
		end else if (ctrl.deq) begin
			ent_d = right_ent;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

endmodule

/* rtl/spq_out_reg.sv */
module spq_out_reg import spq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res_d,
	input  logic    res_stall,
	output logic    res_valid,
	output result_t res
);

	logic    valid_q;
	result_t res_q;

	// Set on load, drop once the word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Capture the payload on load only, so a stalled word holds.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_d;
		end
	end

	assign res_valid = valid_q;
	assign res       = res_q;

endmodule

/* rtl/sorted_priority_queue.sv */
// Sorted priority queue built as a chain of entry cells.
// Input channel: in_valid / in_stall carry one word of cmd, value and prio.
//   cmd 0 enqueues value at priority prio (smaller served first; equal
//   priorities leave in arrival order); cmd 1 dequeues the front entry.
// Result channel: res_valid / res_stall carry one word per input word:
//   status (0 ok, 1 full, 2 empty), out_valid, out_value, out_prio, count.
// Throughput: one word per cycle while in_stall is low. Every cell compares
//   its priority with the incoming one and shifts toward a neighbor in the
//   same cycle.
// Result timing: the result appears in the cycle after the input word is accepted,
//   held in a single output register.
// Stall: while res_valid is high and res_stall is high, in_stall is raised
//   and no input word is accepted; the held result stays unchanged.
// Reset: arst_n clears the fill count and empties the output register.
//   Entry storage is not cleared; cells at or above the fill count are
//   never read.
module sorted_priority_queue import spq_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      cmd,
	input  logic signed [VALUE_W-1:0] value,
	input  logic [PRIO_W-1:0]         prio,
	output logic                      res_valid,
	input  logic                      res_stall,
	output logic [1:0]                status,
	output logic                      out_valid,
	output logic signed [VALUE_W-1:0] out_value,
	output logic [PRIO_W-1:0]         out_prio,
	output logic [COUNT_W-1:0]        count
);

	`include "sorted_priority_queue_macros.svh"

	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] fill_d;
	logic             accept;
	logic             full;
	logic             empty;
	logic             do_enq;
	logic             do_deq;
	cell_ctrl_t       ctrl;
	result_t          res_d;
	result_t          res;
	entry_t           cell_ent [DEPTH];
	logic             cell_gt  [DEPTH];
	logic             occ      [DEPTH];

	// Accept while the output register can take a new word.
	assign in_stall = res_valid && res_stall;
	assign accept   = in_valid && !in_stall;
	assign full     = (fill_q == CNT_W'(DEPTH));
	assign empty    = (fill_q == '0);
	assign do_enq   = accept && (cmd == CMD_ENQ) && !full;
	assign do_deq   = accept && (cmd == CMD_DEQ) && !empty;

	assign ctrl.enq       = do_enq;
	assign ctrl.deq       = do_deq;
	assign ctrl.ent.value = value;
	assign ctrl.ent.prio  = prio_to_store(prio);

	// Advance the fill count.
	always_comb begin
		fill_d = fill_q;
		if (do_enq) begin
			fill_d = fill_q + 1'b1;
		end else if (do_deq) begin
			fill_d = fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else begin
			fill_q <= fill_d;
		end
	end

	// Build the chain; each cell sees its two neighbors.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
		entry_t left_ent;
		logic   left_gt;
		entry_t right_ent;

		assign occ[i] = (IDX < fill_q);

		if (i == 0) begin : g_first
			assign left_ent = '0;
			assign left_gt  = 1'b0;
		end else begin : g_mid
			assign left_ent = cell_ent[i-1];
			assign left_gt  = cell_gt[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_ent = cell_ent[i];
		end else begin : g_inner
			assign right_ent = cell_ent[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occ       (occ[i]),
			.left_ent  (left_ent),
			.left_gt   (left_gt),
			.right_ent (right_ent),
			.ent       (cell_ent[i]),
			.gt        (cell_gt[i])
		);
	end

	// Form the result word.
	always_comb begin
		res_d.status    = ST_OK;
		res_d.out_valid = do_deq;
		res_d.out_value = '0;
		res_d.out_prio  = '0;
		res_d.count     = fill_to_count(fill_d);
		if (cmd == CMD_ENQ && full) begin
			res_d.status = ST_FULL;
		end else if (cmd == CMD_DEQ && empty) begin
			res_d.status = ST_EMPTY;
		end
		if (do_deq) begin
			res_d.out_value = cell_ent[0].value;
			res_d.out_prio  = prio_to_port(cell_ent[0].prio);
		end
	end

	spq_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (accept),
		.res_d     (res_d),
		.res_stall (res_stall),
		.res_valid (res_valid),
		.res       (res)
	);

	assign status    = res.status;
	assign out_valid = res.out_valid;
	assign out_value = res.out_value;
	assign out_prio  = res.out_prio;
	assign count     = res.count;

	`SPQ_ASSERT(a_fill_bound, fill_q <= CNT_W'(DEPTH))
	`SPQ_ASSERT(a_stall_blocks_input, (res_valid && res_stall) |-> !accept)
	`SPQ_ASSERT(a_returned_is_ok, (res_valid && out_valid) |-> (status == ST_OK))
	`SPQ_ASSERT_NEXT(a_deq_drops_fill, do_deq, fill_q == CNT_W'($past(fill_q) - 1'b1))
	`SPQ_ASSERT_NEXT(a_enq_grows_fill, do_enq, fill_q == CNT_W'($past(fill_q) + 1'b1))

endmodule

/* dv/sorted_priority_queue_tb.sv */
module sorted_priority_queue_tb import spq_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_WORDS = 1850;
	localparam int QUIET_WORDS  = 150;
	localparam int STUCK_LIMIT  = 500;
	localparam int DRAIN_CYCLES = 10;

	// One input word plus, for hand-checked rows, the result it must give.
	typedef struct {
		logic                      op;
		logic signed [VALUE_W-1:0] data;
		logic [PRIO_W-1:0]         pri;
		bit                        known;
		result_t                   res;
	} queue_op_t;

	logic                      clk;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_stall;
	logic                      cmd       = CMD_ENQ;
	logic signed [VALUE_W-1:0] value     = '0;
	logic [PRIO_W-1:0]         prio      = '0;
	logic                      res_valid;
	logic                      res_stall = 1'b0;
	logic [1:0]                status;
	logic                      out_valid;
	logic signed [VALUE_W-1:0] out_value;
	logic [PRIO_W-1:0]         out_prio;
	logic [COUNT_W-1:0]        count;

	// Hand-checked expectation travels with the word it belongs to.
	bit      cur_known = 1'b0;
	result_t cur_res   = '0;

	// Shadow copy of the queue contents.
	logic signed [VALUE_W-1:0] shadow_value [DEPTH];
	logic [PRIO_BITS-1:0]      shadow_prio  [DEPTH];
	int                        shadow_fill = 0;

	result_t   pending_results [$];
	queue_op_t directed [$];
	int        errors     = 0;
	int        stuck      = 0;
	bit        quiet      = 1'b0;
	int        burst_left = 0;
	bit        stall_mode;

	sorted_priority_queue u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.value     (value),
		.prio      (prio),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.status    (status),
		.out_valid (out_valid),
		.out_value (out_value),
		.out_prio  (out_prio),
		.count     (count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Apply one word to the shadow queue and return the result it gives.
	function automatic result_t predict_queue_op(input logic op,
			input logic signed [VALUE_W-1:0] data, input logic [PRIO_W-1:0] pri);
		result_t              r;
		logic [PRIO_BITS-1:0] sp;
		int                   pos;
		r = '0;
		sp = PRIO_BITS'(pri);
		if (op == CMD_ENQ) begin
			if (shadow_fill >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				// shift larger priorities up, land after equal ones
				pos = shadow_fill;
				while (pos > 0 && shadow_prio[pos-1] > sp) begin
					shadow_value[pos] = shadow_value[pos-1];
					shadow_prio[pos]  = shadow_prio[pos-1];
					pos--;
				end
				shadow_value[pos] = data;
				shadow_prio[pos]  = sp;
				shadow_fill++;
				r.status = ST_OK;
			end
		end else if (shadow_fill == 0) begin
			r.status = ST_EMPTY;
		end else begin
			// pop the front entry and close the gap
			r.status    = ST_OK;
			r.out_valid = 1'b1;
			r.out_value = shadow_value[0];
			r.out_prio  = PRIO_W'(shadow_prio[0]);
			for (int k = 1; k < shadow_fill; k++) begin
				shadow_value[k-1] = shadow_value[k];
				shadow_prio[k-1]  = shadow_prio[k];
			end
			shadow_fill--;
		end
		r.count = COUNT_W'(shadow_fill);
		return r;
	endfunction

	function automatic queue_op_t row(input logic op, input logic signed [VALUE_W-1:0] data,
			input logic [PRIO_W-1:0] pri);
		queue_op_t w;
		w.op    = op;
		w.data  = data;
		w.pri   = pri;
		w.known = 1'b0;
		w.res   = '0;
		return w;
	endfunction

	function automatic queue_op_t row_known(input logic op,
			input logic signed [VALUE_W-1:0] data, input logic [PRIO_W-1:0] pri,
			input status_t st, input logic ov, input logic signed [VALUE_W-1:0] oval,
			input logic [PRIO_W-1:0] opri, input logic [COUNT_W-1:0] cnt);
		queue_op_t w;
		w = row(op, data, pri);
		w.known         = 1'b1;
		w.res.status    = st;
		w.res.out_valid = ov;
		w.res.out_value = oval;
		w.res.out_prio  = opri;
		w.res.count     = cnt;
		return w;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// Present one word; hold it until the queue takes it.
	task automatic issue(input queue_op_t w);
		if (!quiet && $urandom_range(3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(10, 1)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		cmd       <= w.op;
		value     <= w.data;
		prio      <= w.pri;
		cur_known <= w.known;
		cur_res   <= w.res;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Check result words against the oldest expectation, then predict new input words.
	always @(posedge clk) begin
		result_t want;
		result_t pred;
		bit      moved;
		if (arst_n) begin
			moved = 1'b0;
			if (res_valid && !res_stall) begin
				moved = 1'b1;
				if (pending_results.size() == 0) begin
					$error("result word with no expectation waiting");
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_field("status", 32'(want.status), 32'(status));
					check_field("out_valid", 32'(want.out_valid), 32'(out_valid));
					check_field("out_value", want.out_value, out_value);
					check_field("out_prio", 32'(want.out_prio), 32'(out_prio));
					check_field("count", 32'(want.count), 32'(count));
				end
			end
			if (in_valid && !in_stall) begin
				moved = 1'b1;
				pred = predict_queue_op(cmd, value, prio);
				pending_results.push_back(cur_known ? cur_res : pred);
			end
			stuck <= moved ? 0 : stuck + 1;
		end
	end

	// Stall the result side in random bursts; drop stalls near the end.
	always @(posedge clk) begin
		if (quiet || !arst_n) begin
			res_stall <= 1'b0;
		end else if (burst_left == 0) begin
			stall_mode = ($urandom_range(2) == 0);
			burst_left = stall_mode ? $urandom_range(9, 0) : $urandom_range(19, 0);
			res_stall <= stall_mode;
		end else begin
			burst_left--;
		end
	end

	initial begin
		while (stuck < STUCK_LIMIT) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		logic [PRIO_W-1:0] fill_prio [16];
		int                seg_left;
		int                enq_pct;
		bit                wide;
		queue_op_t         w;

		fill_prio = '{9, 3, 9, 3, 0, 255, 9, 3, 128, 127, 9, 0, 255, 1, 3, 9};

		// Empty after reset, extremes of value and priority.
		directed.push_back(row_known(CMD_DEQ, 32'shDEADBEEF, 8'hA5,
			ST_EMPTY, 1'b0, '0, '0, 5'd0));
		directed.push_back(row_known(CMD_ENQ, 32'sh7FFFFFFF, 8'hFF,
			ST_OK, 1'b0, '0, '0, 5'd1));
		directed.push_back(row_known(CMD_ENQ, 32'sh80000000, 8'h00,
			ST_OK, 1'b0, '0, '0, 5'd2));
		directed.push_back(row_known(CMD_DEQ, 32'sh7FFFFFFF, 8'hFF,
			ST_OK, 1'b1, 32'sh80000000, 8'h00, 5'd1));
		directed.push_back(row_known(CMD_DEQ, 32'sh00000000, 8'h00,
			ST_OK, 1'b1, 32'sh7FFFFFFF, 8'hFF, 5'd0));
		directed.push_back(row_known(CMD_DEQ, 32'shFFFFFFFF, 8'hFF,
			ST_EMPTY, 1'b0, '0, '0, 5'd0));
		// Fill every slot with repeated priorities to exercise arrival order.
		for (int i = 0; i < 16; i++)
			directed.push_back(row(CMD_ENQ, 32'(i) * 32'sh11111111 - 32'sh7, fill_prio[i]));
		directed.push_back(row_known(CMD_ENQ, 32'sh12345678, 8'h00,
			ST_FULL, 1'b0, '0, '0, 5'd16));
		directed.push_back(row(CMD_DEQ, 32'sh0, 8'h0));
		directed.push_back(row(CMD_DEQ, 32'sh0, 8'h0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed[i])
			issue(directed[i]);

		// Random segments, each with its own enqueue bias and priority spread.
		seg_left = 0;
		enq_pct  = 50;
		wide     = 1'b0;
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(60, 20);
				case ($urandom_range(2))
					0: enq_pct = 20;
					1: enq_pct = 50;
					default: enq_pct = 80;
				endcase
				wide = 1'($urandom_range(1));
			end
			seg_left--;
			if (n == RANDOM_WORDS - QUIET_WORDS)
				quiet <= 1'b1;
			w = row($urandom_range(99) < enq_pct ? CMD_ENQ : CMD_DEQ, $urandom,
				PRIO_W'(wide ? $urandom_range(255) : $urandom_range(3)));
			if ($urandom_range(15) == 0) begin
				case ($urandom_range(3))
					0: w.data = 32'sh7FFFFFFF;
					1: w.data = 32'sh80000000;
					2: w.data = 32'sh00000000;
					default: w.data = 32'shFFFFFFFF;
				endcase
			end
			issue(w);
		end
		in_valid <= 1'b0;

		// Drain outstanding results, then watch for strays.
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* sorted_priority_queue.f */
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/spq_out_reg.sv
rtl/sorted_priority_queue.sv
dv/sorted_priority_queue_tb.sv
